### rtl/pva_pkg.sv
`timescale 1ns / 1ps

package pva_pkg;

    // Field widths of the event and result words.
    localparam int NOTE_W  = 7;
    localparam int TIME_W  = 32;
    localparam int VOICE_W = 3;
    localparam int STACK_W = 4;

    // Stack count after reset.
    localparam logic [STACK_W-1:0] STACK_RESET = 4'd1;

    // Event command codes.
    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MATCH  = 6'b000010,
        ST_OFF    = 6'b000100,
        ST_PICK   = 6'b001000,
        ST_OLDEST = 6'b010000,
        ST_WRITE  = 6'b100000
    } state_t;

    // One result word as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [NOTE_W-1:0]  voice_note;
        logic               gate_on;
        logic               detune_down;
        logic               last;
    } result_t;

endpackage

### rtl/pva_in_if.sv
`timescale 1ns / 1ps

interface pva_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [pva_pkg::NOTE_W-1:0]  note;
    logic [pva_pkg::TIME_W-1:0]  now;

    modport source (output valid, output cmd, output note, output now, input ready);
    modport sink   (input valid, input cmd, input note, input now, output ready);
endinterface

### rtl/pva_out_if.sv
`timescale 1ns / 1ps

interface pva_out_if;
    logic                         valid;
    logic                         ready;
    logic [pva_pkg::VOICE_W-1:0]  voice;
    logic [pva_pkg::NOTE_W-1:0]   voice_note;
    logic                         gate_on;
    logic                         detune_down;
    logic                         last;

    modport source (
        output valid, output voice, output voice_note, output gate_on,
        output detune_down, output last, input ready
    );
    modport sink (
        input valid, input voice, input voice_note, input gate_on,
        input detune_down, input last, output ready
    );
endinterface

### rtl/pva_ram.sv
`timescale 1ns / 1ps

module pva_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pva_out_stage.sv
`timescale 1ns / 1ps

module pva_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pva_pkg::result_t  push_data,
    output logic              take,
    output logic              out_valid,
    input  logic              out_ready,
    output pva_pkg::result_t  out_data
);

    logic             valid_reg;
    logic             valid_next;
    pva_pkg::result_t data_reg;

    // The slot can be refilled when empty or when its word leaves this cycle.
    assign take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/pva_seq.sv
`timescale 1ns / 1ps

module pva_seq #(
    parameter int VOICE_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [pva_pkg::NOTE_W-1:0]    in_note,
    input  logic [pva_pkg::TIME_W-1:0]    in_now,
    input  logic                          cfg_wr_en,
    input  logic [pva_pkg::STACK_W-1:0]   cfg_wr_data,
    input  logic                          res_take,
    output logic                          res_push,
    output pva_pkg::result_t              res_data,
    output logic                          ram_re,
    output logic [$clog2(VOICE_COUNT)-1:0] ram_raddr,
    input  logic [pva_pkg::NOTE_W+pva_pkg::TIME_W-1:0] ram_rdata,
    output logic                          ram_we,
    output logic [$clog2(VOICE_COUNT)-1:0] ram_waddr,
    output logic [pva_pkg::NOTE_W+pva_pkg::TIME_W-1:0] ram_wdata
);

    localparam int IDXW   = $clog2(VOICE_COUNT);
    localparam int CNTW   = $clog2(VOICE_COUNT + 1);
    localparam int NOTE_W = pva_pkg::NOTE_W;
    localparam int TIME_W = pva_pkg::TIME_W;
    localparam int ENTW   = NOTE_W + TIME_W;

    pva_pkg::state_t             state_reg, state_next;
    logic                        cmd_reg, cmd_next;
    logic [NOTE_W-1:0]           note_reg, note_next;
    logic [TIME_W-1:0]           now_reg, now_next;
    logic [pva_pkg::STACK_W-1:0] stack_reg;
    logic [CNTW-1:0]             seff_reg, seff_next;
    logic [CNTW-1:0]             copy_reg, copy_next;
    logic [CNTW-1:0]             cnt_reg, cnt_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [IDXW-1:0]             rd_idx_reg, rd_idx_next;
    logic [VOICE_COUNT-1:0]      match_reg, match_next;
    logic [VOICE_COUNT-1:0]      gate_reg, gate_next;
    logic [VOICE_COUNT-1:0]      vld_reg, vld_next;
    logic [IDXW-1:0]             ptr_reg, ptr_next;
    logic [IDXW-1:0]             chosen_reg, chosen_next;
    logic [TIME_W-1:0]           best_t_reg, best_t_next;
    logic [IDXW-1:0]             best_idx_reg, best_idx_next;

    logic [CNTW-1:0]             seff_in;
    logic [NOTE_W-1:0]           q_note;
    logic [TIME_W-1:0]           q_time;
    logic                        scan_issue;
    logic                        scan_done;
    logic                        any_free;
    logic [IDXW-1:0]             free_pick;
    logic [IDXW-1:0]             off_pick;
    logic [VOICE_COUNT-1:0]      off_rest;
    logic [IDXW-1:0]             ptr_after;

    // Low bits of a voice index as carried in a result word.
    function automatic logic [pva_pkg::VOICE_W-1:0] voice_of(input logic [IDXW-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[pva_pkg::VOICE_W-1:0];
    endfunction

    // Effective stack count: zero counts as one, large values saturate.
    always_comb
    begin
        if (stack_reg == '0)
        begin
            seff_in = CNTW'(1);
        end
        else if (int'(stack_reg) > VOICE_COUNT)
        begin
            seff_in = CNTW'(VOICE_COUNT);
        end
        else
        begin
            seff_in = CNTW'(stack_reg);
        end
    end

    // An entry never written reads as zero note and zero time.
    assign q_note = vld_reg[rd_idx_reg] ? ram_rdata[ENTW-1:TIME_W] : '0;
    assign q_time = vld_reg[rd_idx_reg] ? ram_rdata[TIME_W-1:0] : '0;

    assign scan_issue = (32'(cnt_reg) < VOICE_COUNT);
    assign scan_done  = !scan_issue && !rd_pend_reg;

    // First free voice at or after the round-robin pointer.
    always_comb
    begin
        int sum;
        any_free  = 1'b0;
        free_pick = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            sum = int'(ptr_reg) + i;
            if (sum >= VOICE_COUNT)
            begin
                sum = sum - VOICE_COUNT;
            end
            if (!gate_reg[sum])
            begin
                any_free  = 1'b1;
                free_pick = IDXW'(sum);
            end
        end
    end

    // Lowest voice still to be released on a note-off.
    always_comb
    begin
        off_pick = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                off_pick = IDXW'(i);
            end
        end
        off_rest           = match_reg;
        off_rest[off_pick] = 1'b0;
    end

    assign ptr_after = (chosen_reg == IDXW'(VOICE_COUNT - 1)) ? '0 : chosen_reg + 1'b1;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        note_next     = note_reg;
        now_next      = now_reg;
        seff_next     = seff_reg;
        copy_next     = copy_reg;
        cnt_next      = cnt_reg;
        rd_pend_next  = rd_pend_reg;
        rd_idx_next   = rd_idx_reg;
        match_next    = match_reg;
        gate_next     = gate_reg;
        vld_next      = vld_reg;
        ptr_next      = ptr_reg;
        chosen_next   = chosen_reg;
        best_t_next   = best_t_reg;
        best_idx_next = best_idx_reg;
        ram_re        = 1'b0;
        ram_raddr     = cnt_reg[IDXW-1:0];
        ram_we        = 1'b0;
        ram_waddr     = chosen_reg;
        ram_wdata     = {note_reg, now_reg};
        res_push      = 1'b0;
        res_data      = '0;

        // Table sweep shared by the match pass and the oldest-voice pass.
        if ((state_reg == pva_pkg::ST_MATCH) || (state_reg == pva_pkg::ST_OLDEST))
        begin
            rd_pend_next = scan_issue;
            if (scan_issue)
            begin
                ram_re      = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                rd_idx_next = cnt_reg[IDXW-1:0];
            end
        end

        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = in_cmd;
                    note_next    = in_note;
                    now_next     = in_now;
                    seff_next    = seff_in;
                    cnt_next     = '0;
                    rd_pend_next = 1'b0;
                    match_next   = '0;
                    state_next   = pva_pkg::ST_MATCH;
                end
            end

            pva_pkg::ST_MATCH:
            begin
                if (rd_pend_reg)
                begin
                    match_next[rd_idx_reg] = (q_note == note_reg);
                end
                if (scan_done)
                begin
                    if (cmd_reg == pva_pkg::CMD_NOTE_OFF)
                    begin
                        state_next = pva_pkg::ST_OFF;
                    end
                    else if ((seff_reg < CNTW'(2)) && ((match_reg & gate_reg) != '0))
                    begin
                        state_next = pva_pkg::ST_IDLE;
                    end
                    else
                    begin
                        copy_next  = '0;
                        state_next = pva_pkg::ST_PICK;
                    end
                end
            end

            pva_pkg::ST_OFF:
            begin
                if (match_reg == '0)
                begin
                    state_next = pva_pkg::ST_IDLE;
                end
                else if (res_take)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = off_pick;
                    ram_wdata            = {note_reg, {TIME_W{1'b0}}};
                    vld_next[off_pick]   = 1'b1;
                    gate_next[off_pick]  = 1'b0;
                    match_next           = off_rest;
                    res_push             = 1'b1;
                    res_data.voice       = voice_of(off_pick);
                    res_data.voice_note  = note_reg;
                    res_data.gate_on     = 1'b0;
                    res_data.detune_down = 1'b0;
                    res_data.last        = (off_rest == '0);
                    if (off_rest == '0)
                    begin
                        state_next = pva_pkg::ST_IDLE;
                    end
                end
            end

            pva_pkg::ST_PICK:
            begin
                if (any_free)
                begin
                    chosen_next = free_pick;
                    state_next  = pva_pkg::ST_WRITE;
                end
                else
                begin
                    cnt_next      = '0;
                    rd_pend_next  = 1'b0;
                    best_t_next   = now_reg;
                    best_idx_next = '0;
                    state_next    = pva_pkg::ST_OLDEST;
                end
            end

            pva_pkg::ST_OLDEST:
            begin
                // Strictly older only, so the lowest index wins among equals.
                if (rd_pend_reg && (q_time < best_t_reg))
                begin
                    best_t_next   = q_time;
                    best_idx_next = rd_idx_reg;
                end
                if (scan_done)
                begin
                    chosen_next = best_idx_reg;
                    state_next  = pva_pkg::ST_WRITE;
                end
            end

            pva_pkg::ST_WRITE:
            begin
                if (res_take)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = chosen_reg;
                    ram_wdata             = {note_reg, now_reg};
                    vld_next[chosen_reg]  = 1'b1;
                    gate_next[chosen_reg] = 1'b1;
                    ptr_next              = ptr_after;
                    res_push              = 1'b1;
                    res_data.voice        = voice_of(chosen_reg);
                    res_data.voice_note   = note_reg;
                    res_data.gate_on      = 1'b1;
                    res_data.detune_down  = copy_reg[0];
                    res_data.last         = (copy_reg == seff_reg - CNTW'(1));
                    if (copy_reg == seff_reg - CNTW'(1))
                    begin
                        state_next = pva_pkg::ST_IDLE;
                    end
                    else
                    begin
                        copy_next  = copy_reg + 1'b1;
                        state_next = pva_pkg::ST_PICK;
                    end
                end
            end

            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == pva_pkg::ST_IDLE);

    // Stack count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_reg <= pva_pkg::STACK_RESET;
        end
        else if (cfg_wr_en)
        begin
            stack_reg <= cfg_wr_data;
        end
    end

    // Control state and per-voice flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pva_pkg::ST_IDLE;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            copy_reg    <= '0;
            seff_reg    <= CNTW'(1);
            match_reg   <= '0;
            gate_reg    <= '0;
            vld_reg     <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            copy_reg    <= copy_next;
            seff_reg    <= seff_next;
            match_reg   <= match_next;
            gate_reg    <= gate_next;
            vld_reg     <= vld_next;
            ptr_reg     <= ptr_next;
        end
    end

    // Event fields and working values.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        note_reg     <= note_next;
        now_reg      <= now_next;
        rd_idx_reg   <= rd_idx_next;
        chosen_reg   <= chosen_next;
        best_t_reg   <= best_t_next;
        best_idx_reg <= best_idx_next;
    end

endmodule

### rtl/poly_voice_allocator.sv
// Polyphonic voice allocator.
// Event words arrive on in_ch (cmd, note, now); each event causes zero or
// more result words on out_ch (voice, voice_note, gate_on, detune_down,
// last), and last marks the final word of an event. The stack count is
// written through cfg_wr_en / cfg_wr_data; the user must do so only while
// the block is idle, which the block itself does not enforce.
// One event is handled at a time; in_ch.ready is high only when idle.
// Every event first sweeps the voice table memory, one entry a cycle.
// A note-off then releases the matching voices one at a time, lowest
// first, each as soon as the output register can take its word. A
// note-on handles its stacked copies one at a time: each takes a free
// voice, or sweeps the table again to steal the oldest one, and is written.
// Results pass through an output register, so a stalled receiver holds the
// sequencer only once a second result is waiting.
// Reset clears all gates, the round-robin pointer and the entry-written
// flags; unwritten table entries read as note 0, time 0. The stack count
// returns to one.
`timescale 1ns / 1ps

module poly_voice_allocator #(
    parameter int VOICE_COUNT = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pva_in_if.sink                      in_ch,
    pva_out_if.source                   out_ch,
    input  logic                        cfg_wr_en,
    input  logic [pva_pkg::STACK_W-1:0] cfg_wr_data
);

    localparam int IDXW = $clog2(VOICE_COUNT);
    localparam int ENTW = pva_pkg::NOTE_W + pva_pkg::TIME_W;

    logic              ram_re;
    logic [IDXW-1:0]   ram_raddr;
    logic [ENTW-1:0]   ram_rdata;
    logic              ram_we;
    logic [IDXW-1:0]   ram_waddr;
    logic [ENTW-1:0]   ram_wdata;
    logic              res_take;
    logic              res_push;
    pva_pkg::result_t  res_data;
    pva_pkg::result_t  out_data;

    // Voice table: held note and start time of each voice.
    pva_ram #(
        .WIDTH (ENTW),
        .DEPTH (VOICE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Event sequencer.
    pva_seq #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_cmd      (in_ch.cmd),
        .in_note     (in_ch.note),
        .in_now      (in_ch.now),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_take    (res_take),
        .res_push    (res_push),
        .res_data    (res_data),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    // Output register.
    pva_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .take      (res_take),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.voice       = out_data.voice;
    assign out_ch.voice_note  = out_data.voice_note;
    assign out_ch.gate_on     = out_data.gate_on;
    assign out_ch.detune_down = out_data.detune_down;
    assign out_ch.last        = out_data.last;

endmodule

### rtl/pva_checker.sv
`timescale 1ns / 1ps

module pva_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [pva_pkg::VOICE_W-1:0]  out_voice,
    input logic [pva_pkg::NOTE_W-1:0]   out_voice_note,
    input logic                         out_gate_on,
    input logic                         out_detune_down,
    input logic                         out_last
);

    // A stalled result word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({out_voice, out_voice_note, out_gate_on, out_detune_down, out_last}))
    else $error("result word changed while stalled");

    // Events are handled one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second event accepted while one is in progress");

    // Released voices never carry a detune direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_gate_on |-> !out_detune_down)
    else $error("gate-off result with detune_down set");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_voice       (out_ch.voice),
    .out_voice_note  (out_ch.voice_note),
    .out_gate_on     (out_ch.gate_on),
    .out_detune_down (out_ch.detune_down),
    .out_last        (out_ch.last)
);

### dv/poly_voice_allocator_test.sv
`timescale 1ns / 1ps

module poly_voice_allocator_test;

    localparam int VOICE_COUNT   = 8;
    localparam int RANDOM_ITEMS  = 135;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 3000;
    // Row count meaning "work the words out from the voice table copy".
    localparam int WORK_OUT      = -1;

    typedef enum bit {ROW_EVENT, ROW_STACK} row_kind_t;
    typedef enum bit [1:0] {RX_OPEN, RX_COIN, RX_COMB} rx_mode_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic                         cmd;
        logic [pva_pkg::NOTE_W-1:0]   note;
        logic [pva_pkg::TIME_W-1:0]   now;
        logic [pva_pkg::STACK_W-1:0]  stack;
        int                           typed_n;
        pva_pkg::result_t             typed_word;
    } script_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [pva_pkg::STACK_W-1:0]  cfg_wr_data;

    pva_in_if  in_bus ();
    pva_out_if out_bus ();

    poly_voice_allocator #(
        .VOICE_COUNT (VOICE_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_bus),
        .out_ch      (out_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Private copy of the voice table, pointer and stack count.
    bit                           vgate  [VOICE_COUNT];
    bit [pva_pkg::NOTE_W-1:0]     vnote  [VOICE_COUNT];
    bit [pva_pkg::TIME_W-1:0]     vstart [VOICE_COUNT];
    int                           rr_ptr = 0;
    bit [pva_pkg::STACK_W-1:0]    stack_size = pva_pkg::STACK_RESET;

    pva_pkg::result_t             voice_words_due [$];
    script_row_t                  script [$];
    int                           faults = 0;
    int                           idle_cycles = 0;
    int                           burst_left = 0;
    bit                           offering = 1'b0;
    bit                           hold_wanted = 1'b0;
    bit                           hold_taken = 1'b0;

    function automatic pva_pkg::result_t make_word(input int v,
                                                   input logic [pva_pkg::NOTE_W-1:0] nt,
                                                   input logic on, input logic dn,
                                                   input logic fin);
        pva_pkg::result_t w;
        w.voice       = pva_pkg::VOICE_W'(v);
        w.voice_note  = nt;
        w.gate_on     = on;
        w.detune_down = dn;
        w.last        = fin;
        return w;
    endfunction

    // First free voice from the pointer; otherwise the strictly oldest one,
    // falling back to voice 0 when nothing started before now.
    function automatic int choose_voice(input logic [pva_pkg::TIME_W-1:0] now);
        int v;
        int oldest;
        logic [pva_pkg::TIME_W-1:0] oldest_t;
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            v = (rr_ptr + i) % VOICE_COUNT;
            if (!vgate[v])
            begin
                rr_ptr = (v + 1) % VOICE_COUNT;
                return v;
            end
        end
        oldest   = 0;
        oldest_t = now;
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            if (vstart[i] < oldest_t)
            begin
                oldest_t = vstart[i];
                oldest   = i;
            end
        end
        rr_ptr = (oldest + 1) % VOICE_COUNT;
        return oldest;
    endfunction

    // Applies one event to the table copy and, if asked, queues the words it
    // should cause. Returns the number of words.
    function automatic int apply_note_event(input logic cmd,
                                            input logic [pva_pkg::NOTE_W-1:0] note,
                                            input logic [pva_pkg::TIME_W-1:0] now,
                                            input bit record);
        int copies;
        int v;
        int count;
        int last_hit;
        count = 0;
        if (cmd == pva_pkg::CMD_NOTE_ON)
        begin
            if (stack_size == 0)
                copies = 1;
            else if (int'(stack_size) > VOICE_COUNT)
                copies = VOICE_COUNT;
            else
                copies = int'(stack_size);
            // A single-voice note-on for a note already sounding is dropped.
            if (copies < 2)
            begin
                for (int i = 0; i < VOICE_COUNT; i++)
                    if (vgate[i] && vnote[i] == note)
                        return 0;
            end
            for (int k = 0; k < copies; k++)
            begin
                v         = choose_voice(now);
                vgate[v]  = 1'b1;
                vnote[v]  = note;
                vstart[v] = now;
                if (record)
                    voice_words_due.push_back(make_word(v, note, 1'b1, k[0], k == copies - 1));
                count++;
            end
        end
        else
        begin
            last_hit = -1;
            for (int i = 0; i < VOICE_COUNT; i++)
                if (vnote[i] == note)
                    last_hit = i;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                if (vnote[i] == note)
                begin
                    vgate[i]  = 1'b0;
                    vstart[i] = '0;
                    if (record)
                        voice_words_due.push_back(make_word(i, note, 1'b0, 1'b0, i == last_hit));
                    count++;
                end
            end
        end
        return count;
    endfunction

    function automatic void script_event(input logic cmd,
                                         input logic [pva_pkg::NOTE_W-1:0] note,
                                         input logic [pva_pkg::TIME_W-1:0] now, input int n,
                                         input pva_pkg::result_t w);
        script_row_t r;
        r.kind       = ROW_EVENT;
        r.cmd        = cmd;
        r.note       = note;
        r.now        = now;
        r.stack      = '0;
        r.typed_n    = n;
        r.typed_word = w;
        script.push_back(r);
    endfunction

    function automatic void script_stack(input logic [pva_pkg::STACK_W-1:0] value);
        script_row_t r;
        r            = '0;
        r.kind       = ROW_STACK;
        r.stack      = value;
        script.push_back(r);
    endfunction

    task automatic lower_valid();
        if (offering)
        begin
            in_bus.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offers one event word and holds it until the block takes it.
    task automatic offer_event(input logic cmd, input logic [pva_pkg::NOTE_W-1:0] note,
                               input logic [pva_pkg::TIME_W-1:0] now, input bit record);
        in_bus.valid <= 1'b1;
        in_bus.cmd   <= cmd;
        in_bus.note  <= note;
        in_bus.now   <= now;
        offering = 1'b1;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        void'(apply_note_event(cmd, note, now, record));
    endtask

    // Bursts of back-to-back words separated by random gaps.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            lower_valid();
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 10);
        end
    endtask

    // Waits until every expected word has come, then lets the block go quiet
    // in case it is still sweeping for an event that causes no word.
    task automatic settle();
        lower_valid();
        while (voice_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stack(input logic [pva_pkg::STACK_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        stack_size = value;
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        faults++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // Receiver: randomly chosen stall patterns in turn, plus one long
    // hold-off on request so that the block backs up into its input.
    initial
    begin : receiver
        rx_mode_t rx_mode;
        int       mode_left;
        int       hold_left;
        int       cycle_no;
        out_bus.ready <= 1'b0;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        cycle_no  = 0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else if (hold_wanted && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN: out_bus.ready <= 1'b1;
                    RX_COIN: out_bus.ready <= 1'($urandom_range(0, 1));
                    default: out_bus.ready <= (cycle_no % 4 == 0);
                endcase
            end
        end
    end

    // Each accepted result word is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        pva_pkg::result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (voice_words_due.size() == 0)
            begin
                faults++;
                $display("%0t: unexpected word, expected none, got voice %0d note %0d gate %0b",
                         $time, out_bus.voice, out_bus.voice_note, out_bus.gate_on);
            end
            else
            begin
                want = voice_words_due.pop_front();
                if (out_bus.voice !== want.voice)
                    report_field("voice", 32'(want.voice), 32'(out_bus.voice));
                if (out_bus.voice_note !== want.voice_note)
                    report_field("voice_note", 32'(want.voice_note), 32'(out_bus.voice_note));
                if (out_bus.gate_on !== want.gate_on)
                    report_field("gate_on", 32'(want.gate_on), 32'(out_bus.gate_on));
                if (out_bus.detune_down !== want.detune_down)
                    report_field("detune_down", 32'(want.detune_down),
                                 32'(out_bus.detune_down));
                if (out_bus.last !== want.last)
                    report_field("last", 32'(want.last), 32'(out_bus.last));
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                          busy_items;
        int                          phase;
        int                          phase_len;
        int                          pick;
        bit [pva_pkg::NOTE_W-1:0]    pool [8];
        bit [pva_pkg::NOTE_W-1:0]    sounding [$];
        bit [pva_pkg::TIME_W-1:0]    clock_ms;
        logic                        cmd;
        logic [pva_pkg::NOTE_W-1:0]  note;

        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        in_bus.valid <= 1'b0;
        in_bus.cmd   <= pva_pkg::CMD_NOTE_ON;
        in_bus.note  <= '0;
        in_bus.now   <= '0;

        // Directed part. Typed rows are those whose words are plain from the
        // reset state; the rest are worked out from the table copy.
        script_event(pva_pkg::CMD_NOTE_ON,  7'd0,   32'd0, 1,
                     make_word(0, 7'd0, 1'b1, 1'b0, 1'b1));
        script_event(pva_pkg::CMD_NOTE_ON,  7'd127, 32'hFFFF_FFFF, 1,
                     make_word(1, 7'd127, 1'b1, 1'b0, 1'b1));
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd127, 32'd0, 1,
                     make_word(1, 7'd127, 1'b0, 1'b0, 1'b1));
        // Note already sounding with a single voice per note: dropped.
        script_event(pva_pkg::CMD_NOTE_ON,  7'd0,   32'd5, 0, '0);
        // Note-off for a note that no voice holds.
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd5,   32'd0, 0, '0);
        // Every untouched voice still holds note 0 from reset.
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd0,   32'd0, WORK_OUT, '0);
        // A stack count of zero behaves as one.
        script_stack(4'd0);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd42,  32'd10, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd42,  32'd11, 0, '0);
        // Above the voice count the stack saturates: fill, then steal on a tie.
        script_stack(4'd15);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd60,  32'd100, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd61,  32'd100, WORK_OUT, '0);
        script_stack(4'd8);
        // Nothing started before time zero, so voice 0 is taken every time.
        script_event(pva_pkg::CMD_NOTE_ON,  7'd62,  32'd0, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd63,  32'hFFFF_FFFF, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd61,  32'd0, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd62,  32'd0, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd63,  32'd0, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd60,  32'd0, WORK_OUT, '0);
        script_stack(4'd2);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd60,  32'd300, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd60,  32'd301, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd60,  32'd0, WORK_OUT, '0);
        script_stack(4'd3);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd127, 32'h7FFF_FFFF, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd1,   32'h8000_0000, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd127, 32'd0, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd1,   32'd0, WORK_OUT, '0);
        script_stack(4'd1);
        script_event(pva_pkg::CMD_NOTE_ON,  7'd85,  32'h1234_5678, WORK_OUT, '0);
        script_event(pva_pkg::CMD_NOTE_OFF, 7'd85,  32'd0, WORK_OUT, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].kind == ROW_STACK)
            begin
                settle();
                write_stack(script[r].stack);
            end
            else
            begin
                offer_event(script[r].cmd, script[r].note, script[r].now,
                            script[r].typed_n == WORK_OUT);
                if (script[r].typed_n == 1)
                    voice_words_due.push_back(script[r].typed_word);
                pace_sender();
            end
        end

        // Random part: phases of note-on / note-off traffic over a small pool
        // of notes, with a fresh stack count for each phase.
        busy_items = 0;
        phase      = 0;
        clock_ms   = $urandom();
        while (busy_items < RANDOM_ITEMS)
        begin
            settle();
            case (phase)
                0:       write_stack(4'd8);
                1:       write_stack(4'd15);
                2:       write_stack(4'd1);
                3:       write_stack(4'd0);
                4:       write_stack(4'd2);
                default: write_stack(pva_pkg::STACK_W'($urandom_range(0, 15)));
            endcase
            for (int i = 0; i < 8; i++)
                pool[i] = pva_pkg::NOTE_W'($urandom_range(0, 127));
            // The first phase runs under a long receiver hold-off.
            if (phase == 0)
                hold_wanted = 1'b1;
            phase_len = $urandom_range(16, 24);
            for (int j = 0; j < phase_len; j++)
            begin
                // Once, the sender stops mid-phase until the block has drained.
                if (phase == 1 && j == phase_len / 2)
                    settle();
                case ($urandom_range(0, 9))
                    0:       clock_ms = $urandom();
                    1, 2:    clock_ms = clock_ms;
                    default: clock_ms = clock_ms + $urandom_range(1, 40);
                endcase
                if (sounding.size() > 0 &&
                    (sounding.size() > 12 || $urandom_range(0, 9) < 4))
                begin
                    cmd  = pva_pkg::CMD_NOTE_OFF;
                    pick = $urandom_range(0, sounding.size() - 1);
                    note = sounding[pick];
                    sounding.delete(pick);
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: any note, either command.
                    cmd  = $urandom_range(0, 1) ? pva_pkg::CMD_NOTE_OFF : pva_pkg::CMD_NOTE_ON;
                    note = pva_pkg::NOTE_W'($urandom_range(0, 127));
                end
                else
                begin
                    cmd  = pva_pkg::CMD_NOTE_ON;
                    note = pool[$urandom_range(0, 7)];
                    sounding.push_back(note);
                end
                offer_event(cmd, note, clock_ms, 1'b1);
                busy_items++;
                pace_sender();
            end
            phase++;
        end

        settle();
        if (faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/pva_pkg.sv
rtl/pva_in_if.sv
rtl/pva_out_if.sv
rtl/pva_ram.sv
rtl/pva_out_stage.sv
rtl/pva_seq.sv
rtl/poly_voice_allocator.sv
rtl/pva_checker.sv
dv/poly_voice_allocator_test.sv
